FILE: hw/rtl/bwll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwll_pkg: shared types and constants
// Field widths, link table size, sequencer states and divider status used by
// the bandwidth weighted least loaded assignment block.
// ----------------------------------------------------------------------------
package bwll_pkg;

    localparam int MAX_LINKS  = 8;
    localparam int LINK_IDX_W = 3;
    localparam int LINK_CNT_W = 4;
    localparam int BW_W       = 16;
    localparam int SIZE_W     = 32;
    localparam int KEY_W      = 16;
    localparam int LOAD_W     = 48;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index of link_count.
    localparam logic REG_LINK_COUNT = 1'b0;

    // Input command codes.
    localparam logic CMD_SET_BW = 1'b0;
    localparam logic CMD_ASSIGN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVGO,
        ST_DIV,
        ST_ACC
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : bwll_pkg
`default_nettype wire

FILE: hw/rtl/bandwidth_weighted_least_loaded_assign_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bandwidth_weighted_least_loaded_assign_top: link assignment engine
// Keeps per-link bandwidth, accumulated load and unassigned mark, and places
// each assign word on the best link, reporting the link and its new load.
// ----------------------------------------------------------------------------
// A bandwidth word (command 0) is written on acceptance and produces no result.
// An assign word (command 1) runs the sequencer until it is back in idle:
// one compare step for each link after link zero through a single shared
// comparator, a divider start step, then one quotient bit per cycle in the
// restoring divider plus a done step, then the load update (a saturating
// add, or the bare quotient for an unassigned link), which waits while an
// earlier result is still held. in_stall is high for that whole time.
// The result sits in an output register, so the next word is accepted while
// a result still waits on out_stall.
// Unassigned links win first, largest bandwidth first; otherwise the least
// loaded link wins; ties go to the lowest index. Loads are unsigned fixed point
// with LOAD_FRAC_BITS fraction bits and saturate at all ones.
// ----------------------------------------------------------------------------
module bandwidth_weighted_least_loaded_assign_top #(
    parameter int LOAD_FRAC_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bwll_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bwll_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bwll_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    // Input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic [bwll_pkg::LINK_IDX_W-1:0]    link_index,
    input  wire logic [bwll_pkg::BW_W-1:0]          bandwidth,
    input  wire logic [bwll_pkg::SIZE_W-1:0]        item_size,
    input  wire logic [bwll_pkg::KEY_W-1:0]         item_key,
    // Output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [bwll_pkg::LINK_IDX_W-1:0]    chosen_link,
    output logic      [bwll_pkg::KEY_W-1:0]         assigned_key,
    output logic      [bwll_pkg::LOAD_W-1:0]        link_load_after
);

    localparam int NL    = bwll_pkg::MAX_LINKS;
    localparam int IDX_W = bwll_pkg::LINK_IDX_W;
    localparam int CNT_W = bwll_pkg::LINK_CNT_W;
    localparam int BW_W  = bwll_pkg::BW_W;
    localparam int LD_W  = bwll_pkg::LOAD_W;

    // Link tables.
    logic [BW_W-1:0] bw_tab_reg   [NL];
    logic [LD_W-1:0] load_tab_reg [NL];
    logic [NL-1:0]   unas_reg;

    logic [CNT_W-1:0] link_count_reg;

    bwll_pkg::seq_state_t state_reg, state_next;

    // Per-item working registers.
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]           best_idx_reg, best_idx_next;
    logic [BW_W-1:0]            best_bw_reg, best_bw_next;
    logic [LD_W-1:0]            best_load_reg, best_load_next;
    logic                       best_un_reg, best_un_next;
    logic [bwll_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [bwll_pkg::KEY_W-1:0] key_reg, key_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]           out_link_reg, out_link_next;
    logic [bwll_pkg::KEY_W-1:0] out_key_reg, out_key_next;
    logic [LD_W-1:0]            out_load_reg, out_load_next;

    logic in_accept;
    logic out_accept;
    logic cfg_we;
    logic [3:0] cfg_val;
    logic [IDX_W-1:0] last_idx;

    // Shared compare unit inputs: the link under scan against the current best.
    logic [BW_W-1:0] cand_bw;
    logic [LD_W-1:0] cand_load;
    logic            cand_un;
    logic            cand_wins;

    // Divider interface and the update adder.
    logic                  div_start;
    bwll_pkg::div_status_t div_st;
    logic [LD_W-1:0]       quot;
    logic [LD_W:0]         sum_wide;
    logic [LD_W-1:0]       new_load;
    logic                  commit;
    logic                  bw_write;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = (state_reg != bwll_pkg::ST_IDLE);
    assign last_idx   = IDX_W'(link_count_reg - 1'b1);

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_val = pwdata[3:0];
    assign prdata  = (paddr[2] == bwll_pkg::REG_LINK_COUNT)
                   ? bwll_pkg::APB_DATA_W'(link_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_count_reg <= CNT_W'(1);
        end
        else if (cfg_we && (paddr[2] == bwll_pkg::REG_LINK_COUNT))
        begin
            // Out of range counts are clamped into one through MAX_LINKS.
            if (cfg_val == '0)
                link_count_reg <= CNT_W'(1);
            else if (cfg_val > CNT_W'(NL))
                link_count_reg <= CNT_W'(NL);
            else
                link_count_reg <= cfg_val;
        end
    end

    // ------------------------------------------------------------------
    // Compare step: an unassigned link beats an assigned one; among
    // unassigned links the larger bandwidth wins, among assigned ones the
    // smaller load. Strict compares keep ties on the lower index.
    // ------------------------------------------------------------------
    assign cand_bw   = bw_tab_reg[scan_idx_reg];
    assign cand_load = load_tab_reg[scan_idx_reg];
    assign cand_un   = unas_reg[scan_idx_reg];

    always_comb
    begin
        if (cand_un && !best_un_reg)
            cand_wins = 1'b1;
        else if (cand_un && best_un_reg)
            cand_wins = (cand_bw > best_bw_reg);
        else if (!cand_un && !best_un_reg)
            cand_wins = (cand_load < best_load_reg);
        else
            cand_wins = 1'b0;
    end

    // ------------------------------------------------------------------
    // Divider: load increment = (size << LOAD_FRAC_BITS) / bandwidth.
    // ------------------------------------------------------------------
    bwll_divider #(
        .FRAC_BITS (LOAD_FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .size   (size_reg),
        .denom  (best_bw_reg),
        .status (div_st),
        .quot   (quot)
    );

    // A freshly assigned link takes the quotient; otherwise it accumulates
    // with saturation.
    assign sum_wide = {1'b0, best_load_reg} + {1'b0, quot};
    assign new_load = best_un_reg ? quot : (sum_wide[LD_W] ? '1 : sum_wide[LD_W-1:0]);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        best_idx_next  = best_idx_reg;
        best_bw_next   = best_bw_reg;
        best_load_next = best_load_reg;
        best_un_next   = best_un_reg;
        size_next      = size_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_accept;
        out_link_next  = out_link_reg;
        out_key_next   = out_key_reg;
        out_load_next  = out_load_reg;
        div_start      = 1'b0;
        commit         = 1'b0;
        bw_write       = 1'b0;

        case (state_reg)
            bwll_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == bwll_pkg::CMD_SET_BW)
                    begin
                        bw_write = 1'b1;
                    end
                    else
                    begin
                        // Link zero is the starting candidate.
                        size_next      = item_size;
                        key_next       = item_key;
                        best_idx_next  = '0;
                        best_bw_next   = bw_tab_reg[0];
                        best_load_next = load_tab_reg[0];
                        best_un_next   = unas_reg[0];
                        scan_idx_next  = IDX_W'(1);
                        state_next     = (last_idx == '0) ? bwll_pkg::ST_DIVGO
                                                          : bwll_pkg::ST_SCAN;
                    end
                end
            end

            bwll_pkg::ST_SCAN:
            begin
                if (cand_wins)
                begin
                    best_idx_next  = scan_idx_reg;
                    best_bw_next   = cand_bw;
                    best_load_next = cand_load;
                    best_un_next   = cand_un;
                end
                if (scan_idx_reg == last_idx)
                    state_next = bwll_pkg::ST_DIVGO;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end

            bwll_pkg::ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = bwll_pkg::ST_DIV;
            end

            bwll_pkg::ST_DIV:
            begin
                if (div_st.done)
                    state_next = bwll_pkg::ST_ACC;
            end

            bwll_pkg::ST_ACC:
            begin
                // Wait only if the previous result is still held.
                if (!out_valid_reg || out_accept)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    out_link_next  = best_idx_reg;
                    out_key_next   = key_reg;
                    out_load_next  = new_load;
                    state_next     = bwll_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bwll_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bwll_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        best_idx_reg  <= best_idx_next;
        best_bw_reg   <= best_bw_next;
        best_load_reg <= best_load_next;
        best_un_reg   <= best_un_next;
        size_reg      <= size_next;
        key_reg       <= key_next;
        out_link_reg  <= out_link_next;
        out_key_reg   <= out_key_next;
        out_load_reg  <= out_load_next;
    end

    // Link tables: a bandwidth write stores zero as one and marks the link
    // unassigned; a commit stores the new load and marks it assigned.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NL; i++)
            begin
                bw_tab_reg[i]   <= BW_W'(1);
                load_tab_reg[i] <= '0;
            end
            unas_reg <= '1;
        end
        else if (bw_write)
        begin
            bw_tab_reg[link_index] <= (bandwidth == '0) ? BW_W'(1) : bandwidth;
            unas_reg[link_index]   <= 1'b1;
        end
        else if (commit)
        begin
            load_tab_reg[best_idx_reg] <= new_load;
            unas_reg[best_idx_reg]     <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign chosen_link     = out_link_reg;
    assign assigned_key    = out_key_reg;
    assign link_load_after = out_load_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (link_count_reg != '0) && (link_count_reg <= CNT_W'(NL)))
        else $error("link count left its legal range");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == bwll_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bwll_pkg::ST_DIV) |-> (div_st.busy || div_st.done))
        else $error("sequencer waits on an idle divider");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bwll_pkg::ST_DIVGO) |-> ({1'b0, best_idx_reg} < link_count_reg))
        else $error("chosen link lies beyond the link count");

    a_commit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (unas_reg[$past(best_idx_reg)] == 1'b0))
        else $error("assigned link still marked unassigned");

endmodule : bandwidth_weighted_least_loaded_assign_top
`default_nettype wire

FILE: hw/rtl/bwll_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwll_divider: restoring divider for link load
// Computes floor((size << FRAC_BITS) / bandwidth), one quotient bit per cycle,
// and saturates the result to the load width.
// ----------------------------------------------------------------------------
module bwll_divider #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [bwll_pkg::SIZE_W-1:0]         size,
    input  wire logic [bwll_pkg::BW_W-1:0]           denom,
    output bwll_pkg::div_status_t                    status,
    output logic      [bwll_pkg::LOAD_W-1:0]         quot
);

    localparam int NUM_W = bwll_pkg::SIZE_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int BW_W  = bwll_pkg::BW_W;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [BW_W-1:0]  rem_reg, rem_next;
    logic [BW_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [BW_W:0] shifted;
    logic [BW_W:0] diff;
    logic          fits;

    // The numerator shifts out of the top of quo_reg while quotient bits
    // enter at the bottom.
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = NUM_W'(size) << FRAC_BITS;
            rem_next = '0;
            den_next = denom;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? diff[BW_W-1:0] : shifted[BW_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

    generate
        if (NUM_W > bwll_pkg::LOAD_W)
        begin : g_sat
            assign quot = (|quo_reg[NUM_W-1:bwll_pkg::LOAD_W]) ? '1
                        : quo_reg[bwll_pkg::LOAD_W-1:0];
        end
        else
        begin : g_nosat
            assign quot = bwll_pkg::LOAD_W'(quo_reg);
        end
    endgenerate

endmodule : bwll_divider
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the link assignment engine
// Drives bandwidth and assign words through the valid/stall input channel,
// programs link_count over the APB-style port between phases, predicts every
// assignment with a local model of the link tables and compares each result
// word field by field, in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int              LOAD_FRAC_BITS = 16;
    localparam logic [47:0]     LOAD_SAT       = 48'hFFFF_FFFF_FFFF;
    // Register index of a slot that does not exist; writes must be ignored.
    localparam logic            REG_SPARE      = ~bwll_pkg::REG_LINK_COUNT;
    // Cycles the bench lets pass after the last result before touching the
    // configuration; enough to cover one full assign pass.
    localparam int              SETTLE_CYCLES  = 64;
    // Cycles with no accepted word on any port before the run is declared hung.
    localparam int              HANG_LIMIT     = 2000;
    localparam int              RANDOM_PHASES  = 7;
    localparam int              PHASE_WORDS    = 200;

    // One expected result word.
    typedef struct {
        logic [bwll_pkg::LINK_IDX_W-1:0]  link;
        logic [bwll_pkg::KEY_W-1:0]       key;
        logic [bwll_pkg::LOAD_W-1:0]      load;
    } assignment_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [bwll_pkg::APB_ADDR_W-1:0]      paddr;
    logic [bwll_pkg::APB_DATA_W-1:0]      pwdata;
    logic [bwll_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 command;
    logic [bwll_pkg::LINK_IDX_W-1:0]      link_index;
    logic [bwll_pkg::BW_W-1:0]            bandwidth;
    logic [bwll_pkg::SIZE_W-1:0]          item_size;
    logic [bwll_pkg::KEY_W-1:0]           item_key;
    logic                                 out_valid;
    logic                                 out_stall;
    logic [bwll_pkg::LINK_IDX_W-1:0]      chosen_link;
    logic [bwll_pkg::KEY_W-1:0]           assigned_key;
    logic [bwll_pkg::LOAD_W-1:0]          link_load_after;

    // Local copy of the link tables and the link_count register.
    logic [bwll_pkg::BW_W-1:0]            link_bw   [bwll_pkg::MAX_LINKS];
    logic [bwll_pkg::LOAD_W-1:0]          link_load [bwll_pkg::MAX_LINKS];
    bit                                   link_fresh[bwll_pkg::MAX_LINKS];
    int unsigned                          active_links;

    // Assignments predicted but not yet seen on the output channel.
    assignment_t                          pending_assignments[$];

    int unsigned                          error_count;
    int unsigned                          quiet_cycles;

    // Sender burst shaping and receiver stall pattern.
    bit                                   gaps_enabled;
    int unsigned                          burst_left;
    bit                                   stall_enabled;
    bit                                   stall_level;
    int unsigned                          stall_left;

    bandwidth_weighted_least_loaded_assign_top #(
        .LOAD_FRAC_BITS (LOAD_FRAC_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .link_index      (link_index),
        .bandwidth       (bandwidth),
        .item_size       (item_size),
        .item_key        (item_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .chosen_link     (chosen_link),
        .assigned_key    (assigned_key),
        .link_load_after (link_load_after)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Load added by one item: (size << frac) / bandwidth, floored, with zero
    // bandwidth read as one and the quotient clamped to the load width.
    function automatic logic [bwll_pkg::LOAD_W-1:0] load_increment(
        logic [bwll_pkg::SIZE_W-1:0] size, logic [bwll_pkg::BW_W-1:0] bw);
        logic [63:0] numerator;
        logic [63:0] quotient;
        numerator = {32'b0, size} << LOAD_FRAC_BITS;
        quotient  = numerator / ((bw == '0) ? 64'd1 : {48'b0, bw});
        return (quotient > {16'b0, LOAD_SAT}) ? LOAD_SAT
                                              : quotient[bwll_pkg::LOAD_W-1:0];
    endfunction

    // Applies one accepted input word to the link tables. An assign word
    // queues the result word the block has to produce for it.
    task automatic track_link_word(logic cmd, logic [bwll_pkg::LINK_IDX_W-1:0] idx,
                                   logic [bwll_pkg::BW_W-1:0] bw,
                                   logic [bwll_pkg::SIZE_W-1:0] size,
                                   logic [bwll_pkg::KEY_W-1:0] key);
        int unsigned  best;
        logic [48:0]  total;
        assignment_t  result;
        if (cmd == bwll_pkg::CMD_SET_BW)
        begin
            link_bw[idx]    = (bw == '0) ? bwll_pkg::BW_W'(1) : bw;
            link_fresh[idx] = 1'b1;
        end
        else
        begin
            // Fresh links beat assigned ones, bigger bandwidth first among fresh
            // links, least load among assigned ones; strict compares keep ties
            // on the lowest index.
            best = 0;
            for (int unsigned i = 1; i < active_links; i++)
            begin
                if (link_fresh[i] && !link_fresh[best])
                    best = i;
                else if (link_fresh[i] && link_fresh[best])
                begin
                    if (link_bw[i] > link_bw[best])
                        best = i;
                end
                else if (!link_fresh[i] && !link_fresh[best])
                begin
                    if (link_load[i] < link_load[best])
                        best = i;
                end
            end
            // A fresh link starts over, so any load left from before a bandwidth
            // write is dropped here.
            total = {1'b0, load_increment(size, link_bw[best])};
            if (!link_fresh[best])
                total = total + {1'b0, link_load[best]};
            if (total > {1'b0, LOAD_SAT})
                total = {1'b0, LOAD_SAT};
            link_load[best]  = total[bwll_pkg::LOAD_W-1:0];
            link_fresh[best] = 1'b0;
            result.link = bwll_pkg::LINK_IDX_W'(best);
            result.key  = key;
            result.load = total[bwll_pkg::LOAD_W-1:0];
            pending_assignments.push_back(result);
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Presents one word and holds it until the block takes it. In gap mode the
    // sender runs in bursts; between bursts valid drops for a random stretch.
    task automatic send_link_word(logic cmd, logic [bwll_pkg::LINK_IDX_W-1:0] idx,
                                  logic [bwll_pkg::BW_W-1:0] bw,
                                  logic [bwll_pkg::SIZE_W-1:0] size,
                                  logic [bwll_pkg::KEY_W-1:0] key);
        int unsigned gap;
        if (gaps_enabled && burst_left == 0)
        begin
            gap = $urandom_range(1, 30);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        else
            @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        in_valid   <= 1'b1;
        command    <= cmd;
        link_index <= idx;
        bandwidth  <= bw;
        item_size  <= size;
        item_key   <= key;
        // Inputs settle at the falling edge; the block takes the word at the
        // first rising edge with in_stall low.
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        track_link_word(cmd, idx, bw, size, key);
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register over the configuration port. The caller makes sure
    // the block is idle. A setup phase is followed by an access phase.
    task automatic write_register(logic index, logic [bwll_pkg::APB_DATA_W-1:0] value);
        logic [3:0] count;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        if (index == bwll_pkg::REG_LINK_COUNT)
        begin
            count = value[3:0];
            if (count == 4'd0)
                count = 4'd1;
            if (count > bwll_pkg::MAX_LINKS)
                count = 4'(bwll_pkg::MAX_LINKS);
            active_links = 32'(count);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Brings the block to idle and then programs a new link_count. A bandwidth
    // word makes no result, so the bench waits out one assign pass as well.
    task automatic reprogram_link_count(logic [bwll_pkg::APB_DATA_W-1:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(bwll_pkg::REG_LINK_COUNT, value);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall pattern: runs of stall and of no stall with random lengths.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!stall_enabled)
            out_stall <= 1'b0;
        else if (stall_left == 0)
        begin
            stall_level = ($urandom_range(0, 1) == 1);
            stall_left  = stall_level ? $urandom_range(1, 20) : $urandom_range(1, 12);
            out_stall  <= stall_level;
        end
        else
            stall_left--;
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result word is matched against the
    // oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        assignment_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_assignments.size() == 0)
            begin
                $error("result word with no assignment pending: link %0d key %0h",
                       chosen_link, assigned_key);
                error_count++;
            end
            else
            begin
                want = pending_assignments.pop_front();
                if (chosen_link !== want.link)
                begin
                    $error("chosen_link mismatch: expected %0d, actual %0d",
                           want.link, chosen_link);
                    error_count++;
                end
                if (assigned_key !== want.key)
                begin
                    $error("assigned_key mismatch: expected %0h, actual %0h",
                           want.key, assigned_key);
                    error_count++;
                end
                if (link_load_after !== want.load)
                begin
                    $error("link_load_after mismatch: expected %0h, actual %0h",
                           want.load, link_load_after);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted word on either channel or the configuration port
    // counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With the reset value of link_count only link 0 takes part. Covers zero
    // and full item size, both key extremes, saturation of the sum, and a
    // bandwidth write (zero stored as one) that restarts the link load.
    task automatic test_single_link_and_saturation();
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0000_0000, 16'h0000);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd5, 16'h1234, 32'hFFFF_FFFF, 16'h8001);
        send_link_word(bwll_pkg::CMD_SET_BW, 3'd0, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd2, 16'h0000, 32'h0000_0001, 16'h00FF);
    endtask

    // link_count clamping at both ends, a write to a register that does not
    // exist, and ties among equal fresh links going to the lowest index.
    task automatic test_link_count_limits();
        reprogram_link_count(32'h0000_0000);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0000_0010, 16'h0101);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        reprogram_link_count(32'hFFFF_FFFF);
        // Links 1 to 7 are still fresh with bandwidth one, so they are taken
        // in index order; then the least loaded link wins.
        for (int i = 0; i < 9; i++)
            send_link_word(bwll_pkg::CMD_ASSIGN, 3'(i), 16'(i), 32'(100 + i),
                           16'(16'h0200 + i));
    endtask

    // The widest fresh link wins; a link written above link_count waits until
    // link_count covers it.
    task automatic test_bandwidth_priority();
        send_link_word(bwll_pkg::CMD_SET_BW, 3'd5, 16'hFFFF, 32'h0000_0000, 16'h0000);
        send_link_word(bwll_pkg::CMD_SET_BW, 3'd3, 16'h8000, 32'h0000_0000, 16'h0000);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0001_0000, 16'h0301);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0001_0000, 16'h0302);
        reprogram_link_count(32'h0000_0002);
        send_link_word(bwll_pkg::CMD_SET_BW, 3'd7, 16'd1000, 32'h0000_0000, 16'h0000);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0000_0400, 16'h0303);
        reprogram_link_count(32'h0000_0008);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0000_0400, 16'h0304);
        send_link_word(bwll_pkg::CMD_ASSIGN, 3'd0, 16'h0000, 32'h0000_0400, 16'h0305);
    endtask

    function automatic logic [bwll_pkg::BW_W-1:0] pick_bandwidth();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [bwll_pkg::SIZE_W-1:0] pick_item_size();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFF_FFFF;
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Random traffic in phases, each with its own link_count and idling mode.
    // Each phase starts by writing every link's bandwidth, then mixes mostly
    // assign words with occasional bandwidth rewrites; ignored fields carry
    // random bits too.
    task automatic test_random_traffic();
        logic [bwll_pkg::APB_DATA_W-1:0] count_values[RANDOM_PHASES];
        logic                            cmd;
        count_values[0] = 32'd8;
        count_values[1] = 32'd1;
        count_values[2] = $urandom_range(2, 7);
        count_values[3] = 32'd15;
        count_values[4] = 32'd0;
        count_values[5] = $urandom;
        count_values[6] = 32'd8;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            reprogram_link_count(count_values[phase]);
            gaps_enabled  = (phase % 3 != 0);
            stall_enabled = (phase % 3 != 1) || (phase == 1);
            burst_left    = 0;
            for (int i = 0; i < bwll_pkg::MAX_LINKS; i++)
                send_link_word(bwll_pkg::CMD_SET_BW, 3'(i), pick_bandwidth(), $urandom,
                               16'($urandom));
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                cmd = ($urandom_range(0, 4) == 0) ? bwll_pkg::CMD_SET_BW
                                                  : bwll_pkg::CMD_ASSIGN;
                send_link_word(cmd, 3'($urandom), pick_bandwidth(), pick_item_size(),
                               16'($urandom));
                // Once in the run the sender holds off until the block is empty.
                if (phase == 3 && n == PHASE_WORDS / 2)
                    wait_results_drained();
            end
        end
        stall_enabled = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        command       <= bwll_pkg::CMD_SET_BW;
        link_index    <= '0;
        bandwidth     <= '0;
        item_size     <= '0;
        item_key      <= '0;
        gaps_enabled  = 1'b0;
        burst_left    = 0;
        stall_enabled = 1'b0;
        active_links  = 1;
        for (int i = 0; i < bwll_pkg::MAX_LINKS; i++)
        begin
            link_bw[i]    = 16'd1;
            link_load[i]  = '0;
            link_fresh[i] = 1'b1;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_link_and_saturation();
        test_link_count_limits();
        stall_enabled = 1'b1;
        gaps_enabled  = 1'b1;
        test_bandwidth_priority();
        test_random_traffic();

        // Let the last results come home, then a little longer to catch any
        // stray result word.
        wait_results_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (error_count == 0 && pending_assignments.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
